### hdl/scg_pkg.sv
package scg_pkg;

  localparam int unsigned SQ_PAIRS  = 46;  // root bits of |d|^2 * 2^24
  localparam int unsigned SQ_PAD    = 12;  // low root pairs fed by the 24 zero bits
  localparam int unsigned DIV_STEPS = 30;  // normal fraction bits after the integer bit
  localparam logic [15:0] DF_RESET  = 16'd4096;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

  // per-pair data that rides along the pipeline
  typedef struct packed {
    logic [2:0][31:0] pa;
    logic [2:0][32:0] dmag;
    logic [2:0]       dneg;
    logic [30:0]      ra;
    logic [30:0]      rb;
    logic             ce;
  } pair_t;

  function automatic logic [31:0] sat32(input logic signed [36:0] v);
    logic [31:0] r;
    if (v > 37'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -37'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### hdl/sphere_pair_contact_geometry_core.sv
// Sphere pair contact geometry, streaming.
// Input channel in_valid/in_ready carries one sphere pair per beat: both
// centers, the periodic shift of the second, both radii and contact_exists.
// Output channel out_valid/out_ready carries one result beat per input beat,
// in order: contact flag, unit normal (Q2.30), penetration, contact point and
// both radii. Without contact every payload field of the beat is zero.
// detection_factor (Q4.12) is written through cfg_we/cfg_data, one cycle,
// and must only change while the pipe is empty.
// The pipe has 3 offset/square stages, 46 square root stages (one
// root bit each), 31 divider stages (one normal bit each, three lanes) and
// 4 stages for the lever product, saturation and the output register.
// One beat per cycle unless stalled. The whole pipe advances together; when
// out_valid is high and out_ready low every stage holds and in_ready drops.
// Reset clears all valid bits and loads detection_factor with 1.0.
module sphere_pair_contact_geometry_core import scg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] pos_a_x,
  input  logic signed [31:0] pos_a_y,
  input  logic signed [31:0] pos_a_z,
  input  logic signed [31:0] pos_b_x,
  input  logic signed [31:0] pos_b_y,
  input  logic signed [31:0] pos_b_z,
  input  logic signed [31:0] shift_x,
  input  logic signed [31:0] shift_y,
  input  logic signed [31:0] shift_z,
  input  logic [30:0] radius_a,
  input  logic [30:0] radius_b,
  input  logic        contact_exists,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        in_contact,
  output logic signed [31:0] normal_x,
  output logic signed [31:0] normal_y,
  output logic signed [31:0] normal_z,
  output logic signed [31:0] penetration,
  output logic signed [31:0] contact_x,
  output logic signed [31:0] contact_y,
  output logic signed [31:0] contact_z,
  output logic [30:0] radius_a_out,
  output logic [30:0] radius_b_out
);

  logic [15:0] detection_factor;
  logic        adv;

  logic        f_v;
  pair_t       f_pair;
  logic [47:0] f_sdet;
  logic [67:0] f_sq;

  logic        s_v;
  pair_t       s_pair;
  logic [47:0] s_sdet;
  logic [45:0] s_root;

  logic        d_v;
  pair_t       d_pair;
  logic        d_contact;
  logic [33:0] d_len;
  logic [2:0][30:0] d_u;

  logic [2:0][31:0] nrm, cpt;
  logic [31:0]      pen;

  // single global advance; output register is the last stage
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) detection_factor <= DF_RESET;
    else if (cfg_we) detection_factor <= cfg_data;
  end

  scg_front u_front (
    .clk(clk), .rst(rst), .adv(adv),
    .in_v(in_valid && in_ready),
    .pa({pos_a_z, pos_a_y, pos_a_x}),
    .pb({pos_b_z, pos_b_y, pos_b_x}),
    .sh({shift_z, shift_y, shift_x}),
    .ra(radius_a), .rb(radius_b), .ce(contact_exists),
    .df(detection_factor),
    .out_v(f_v), .out_pair(f_pair), .out_sdet(f_sdet), .out_sq(f_sq)
  );

  // floor(sqrt(|d|^2 * 2^24)), compared against the scaled radius sum
  scg_sqrt u_sqrt (
    .clk(clk), .rst(rst), .adv(adv),
    .in_v(f_v), .in_pair(f_pair), .in_sdet(f_sdet), .in_sq(f_sq),
    .out_v(s_v), .out_pair(s_pair), .out_sdet(s_sdet), .out_root(s_root)
  );

  // |d_i| * 2^30 / length, restoring, one bit per stage
  scg_div u_div (
    .clk(clk), .rst(rst), .adv(adv),
    .in_v(s_v), .in_pair(s_pair), .in_sdet(s_sdet), .in_root(s_root),
    .out_v(d_v), .out_pair(d_pair), .out_contact(d_contact),
    .out_len(d_len), .out_u(d_u)
  );

  scg_back u_back (
    .clk(clk), .rst(rst), .adv(adv),
    .in_v(d_v), .in_pair(d_pair), .in_contact(d_contact),
    .in_len(d_len), .in_u(d_u),
    .out_v(out_valid), .in_contact_q(in_contact),
    .normal(nrm), .pen_q(pen), .cpt(cpt),
    .ra_q(radius_a_out), .rb_q(radius_b_out)
  );

  assign normal_x    = nrm[0];
  assign normal_y    = nrm[1];
  assign normal_z    = nrm[2];
  assign contact_x   = cpt[0];
  assign contact_y   = cpt[1];
  assign contact_z   = cpt[2];
  assign penetration = pen;

  a_no_contact_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_contact |-> penetration == 0 && normal_x == 0 && contact_x == 0
      && radius_a_out == 0)
    else $error("non-contact beat carries data");

  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_contact |-> normal_x <= 32'sh4000_0000 && normal_x >= -32'sh4000_0000
      && normal_z <= 32'sh4000_0000 && normal_z >= -32'sh4000_0000)
    else $error("normal component out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

### hdl/scg_front.sv
module scg_front import scg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_v,
  input  logic [2:0][31:0]  pa,
  input  logic [2:0][31:0]  pb,
  input  logic [2:0][31:0]  sh,
  input  logic [30:0]       ra,
  input  logic [30:0]       rb,
  input  logic              ce,
  input  logic [15:0]       df,
  output logic              out_v,
  output pair_t             out_pair,
  output logic [47:0]       out_sdet,
  output logic [67:0]       out_sq
);

  pair_t       pair_next;
  pair_t       p1, p2;
  logic [47:0] s1, s2;
  logic [2:0][65:0] prod;
  logic        v1, v2;

  always_comb begin
    logic signed [33:0] d;
    pair_next = '0;
    for (int i = 0; i < 3; i++) begin
      d = $signed({{2{pb[i][31]}}, pb[i]}) + $signed({{2{sh[i][31]}}, sh[i]})
        - $signed({{2{pa[i][31]}}, pa[i]});
      pair_next.pa[i]   = pa[i];
      pair_next.dneg[i] = d[33];
      pair_next.dmag[i] = d[33] ? 33'(-d) : d[32:0];
    end
    pair_next.ra = ra;
    pair_next.rb = rb;
    pair_next.ce = ce;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; out_v <= 1'b0;
    end else if (adv) begin
      v1 <= in_v; v2 <= v1; out_v <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1 <= pair_next;
      s1 <= df * ({1'b0, ra} + {1'b0, rb});
      p2 <= p1;
      s2 <= s1;
      for (int i = 0; i < 3; i++) prod[i] <= p1.dmag[i] * p1.dmag[i];
      out_pair <= p2;
      out_sdet <= s2;
      out_sq   <= {2'b00, prod[0]} + {2'b00, prod[1]} + {2'b00, prod[2]};
    end
  end

endmodule

### hdl/scg_sqrt.sv
module scg_sqrt import scg_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_v,
  input  pair_t         in_pair,
  input  logic [47:0]   in_sdet,
  input  logic [67:0]   in_sq,
  output logic          out_v,
  output pair_t         out_pair,
  output logic [47:0]   out_sdet,
  output logic [45:0]   out_root
);

  logic [SQ_PAIRS:0] sv;
  pair_t       sp  [0:SQ_PAIRS];
  logic [47:0] ss  [0:SQ_PAIRS];
  logic [67:0] sqq [0:SQ_PAIRS];
  logic [45:0] rt  [0:SQ_PAIRS];
  logic [48:0] rm  [0:SQ_PAIRS];

  assign sv[0]  = in_v;
  assign sp[0]  = in_pair;
  assign ss[0]  = in_sdet;
  assign sqq[0] = in_sq;
  assign rt[0]  = '0;
  assign rm[0]  = '0;

  // one root bit per stage, radicand pair picked by stage position
  for (genvar k = 0; k < SQ_PAIRS; k++) begin : g_st
    localparam int I = SQ_PAIRS - 1 - k;
    logic [1:0]  bits;
    logic [48:0] remsh, trial;
    logic        ge;

    if (I >= SQ_PAD) begin : g_b
      assign bits = sqq[k][2*I-2*SQ_PAD +: 2];
    end else begin : g_z
      assign bits = 2'b00;
    end

    assign remsh = {rm[k][46:0], bits};
    assign trial = {1'b0, rt[k], 2'b01};
    assign ge    = remsh >= trial;

    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else if (adv) sv[k+1] <= sv[k];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sp[k+1]  <= sp[k];
        ss[k+1]  <= ss[k];
        sqq[k+1] <= sqq[k];
        rm[k+1]  <= ge ? remsh - trial : remsh;
        rt[k+1]  <= {rt[k][44:0], ge};
      end
    end
  end

  assign out_v    = sv[SQ_PAIRS];
  assign out_pair = sp[SQ_PAIRS];
  assign out_sdet = ss[SQ_PAIRS];
  assign out_root = rt[SQ_PAIRS];

endmodule

### hdl/scg_div.sv
module scg_div import scg_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_v,
  input  pair_t            in_pair,
  input  logic [47:0]      in_sdet,
  input  logic [45:0]      in_root,
  output logic             out_v,
  output pair_t            out_pair,
  output logic             out_contact,
  output logic [33:0]      out_len,
  output logic [2:0][30:0] out_u
);

  logic [DIV_STEPS:0]  dv;
  pair_t               dp [0:DIV_STEPS];
  logic                dc [0:DIV_STEPS];
  logic [33:0]         dl [0:DIV_STEPS];
  logic [2:0][30:0]    dq [0:DIV_STEPS];
  logic [2:0][34:0]    dr [0:DIV_STEPS];
  logic [33:0]         len0;

  assign len0 = in_root[45:12];

  // integer bit of the quotient; dmag < 2*len so it is 0 or 1
  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (adv) dv[0] <= in_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dp[0] <= in_pair;
      dc[0] <= (in_sdet > {2'b00, in_root}) || in_pair.ce;
      dl[0] <= len0;
      for (int i = 0; i < 3; i++) begin
        if ({1'b0, in_pair.dmag[i]} >= len0) begin
          dq[0][i] <= 31'd1;
          dr[0][i] <= 35'({1'b0, in_pair.dmag[i]} - len0);
        end else begin
          dq[0][i] <= 31'd0;
          dr[0][i] <= {2'b00, in_pair.dmag[i]};
        end
      end
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_st
    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else if (adv) dv[k+1] <= dv[k];
    end

    always_ff @(posedge clk) begin
      logic [35:0] r2;
      logic        ge;
      if (adv) begin
        dp[k+1] <= dp[k];
        dc[k+1] <= dc[k];
        dl[k+1] <= dl[k];
        for (int i = 0; i < 3; i++) begin
          r2 = {dr[k][i], 1'b0};
          ge = r2 >= {2'b00, dl[k]};
          dr[k+1][i] <= ge ? 35'(r2 - {2'b00, dl[k]}) : r2[34:0];
          dq[k+1][i] <= {dq[k][i][29:0], ge};
        end
      end
    end
  end

  assign out_v       = dv[DIV_STEPS];
  assign out_pair    = dp[DIV_STEPS];
  assign out_contact = dc[DIV_STEPS];
  assign out_len     = dl[DIV_STEPS];

  // zero length gives a zero normal; otherwise clamp to one
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dl[DIV_STEPS] == '0) out_u[i] = '0;
      else if (dq[DIV_STEPS][i] > ONE_Q30) out_u[i] = ONE_Q30;
      else out_u[i] = dq[DIV_STEPS][i];
    end
  end

endmodule

### hdl/scg_back.sv
module scg_back import scg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_v,
  input  pair_t             in_pair,
  input  logic              in_contact,
  input  logic [33:0]       in_len,
  input  logic [2:0][30:0]  in_u,
  output logic              out_v,
  output logic              in_contact_q,
  output logic [2:0][31:0]  normal,
  output logic [31:0]       pen_q,
  output logic [2:0][31:0]  cpt,
  output logic [30:0]       ra_q,
  output logic [30:0]       rb_q
);

  logic signed [35:0] h, pen_in;
  logic v1, v2, v3;
  pair_t p1, p2, p3;
  logic  c1, c2, c3;
  logic signed [35:0] pen1, pen2, pen3;
  logic [34:0] hmag1;
  logic [2:0]  sneg1, sneg2, sneg3;
  logic [2:0][30:0] u1, u2, u3;
  logic [2:0][48:0] plo;
  logic [2:0][47:0] phi;
  logic [2:0][34:0] off;

  assign h = $signed({5'b0, in_pair.ra}) - $signed({5'b0, in_pair.rb})
           + $signed({2'b0, in_len});
  assign pen_in = $signed({5'b0, in_pair.ra}) + $signed({5'b0, in_pair.rb})
                - $signed({2'b0, in_len});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; out_v <= 1'b0;
    end else if (adv) begin
      v1 <= in_v; v2 <= v1; v3 <= v2; out_v <= v3;
    end
  end

  always_ff @(posedge clk) begin
    logic [65:0]        prod;
    logic signed [36:0] c;
    if (adv) begin
      // lever (twice) and penetration
      p1    <= in_pair;
      c1    <= in_contact;
      pen1  <= pen_in;
      hmag1 <= h[35] ? 35'(-h) : h[34:0];
      u1    <= in_u;
      for (int i = 0; i < 3; i++) sneg1[i] <= h[35] ^ in_pair.dneg[i];
      // split product, 35 x 31 in two halves
      p2 <= p1; c2 <= c1; pen2 <= pen1; u2 <= u1; sneg2 <= sneg1;
      for (int i = 0; i < 3; i++) begin
        plo[i] <= hmag1[17:0] * u1[i];
        phi[i] <= hmag1[34:18] * u1[i];
      end
      // recombine, scale down by 2^31
      p3 <= p2; c3 <= c2; pen3 <= pen2; u3 <= u2; sneg3 <= sneg2;
      for (int i = 0; i < 3; i++) begin
        prod   = {phi[i], 18'b0} + {17'b0, plo[i]};
        off[i] <= prod[65:31];
      end
      // output register, all zero without contact
      in_contact_q <= c3;
      pen_q        <= c3 ? sat32({pen3[35], pen3}) : '0;
      ra_q         <= c3 ? p3.ra : '0;
      rb_q         <= c3 ? p3.rb : '0;
      for (int i = 0; i < 3; i++) begin
        c = sneg3[i] ? $signed({{5{p3.pa[i][31]}}, p3.pa[i]}) - $signed({2'b0, off[i]})
                     : $signed({{5{p3.pa[i][31]}}, p3.pa[i]}) + $signed({2'b0, off[i]});
        cpt[i]    <= c3 ? sat32(c) : '0;
        normal[i] <= !c3 ? '0 : (p3.dneg[i] ? 32'(-{1'b0, u3[i]}) : {1'b0, u3[i]});
      end
    end
  end

endmodule
